// File: rtl/utf16_to_utf8_transcoder_top_assert.svh
// assertion macros shared by the transcoder queue and back modules
`ifndef UTF16_TO_UTF8_TRANSCODER_TOP_ASSERT_SVH
`define UTF16_TO_UTF8_TRANSCODER_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define U16U8_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define U16U8_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/u16u8_pkg.sv
package u16u8_pkg;

	localparam int QUEUE_AW = 1;

	localparam logic [5:0] SURR_HIGH_TAG = 6'b110110;
	localparam logic [5:0] SURR_LOW_TAG  = 6'b110111;
	localparam logic [20:0] SUPP_BASE    = 21'h10000;

	localparam logic [7:0] LEAD_2 = 8'd192;
	localparam logic [7:0] LEAD_3 = 8'd224;
	localparam logic [7:0] LEAD_4 = 8'd240;
	localparam logic [7:0] CONT   = 8'd128;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        last_unit;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       char_done;
		logic       string_done;
		logic       bad_sequence;
	} out_beat_t;

	typedef enum logic {
		JOB_CHAR,
		JOB_ERR
	} job_kind_t;

	// one queued job: a code point to encode or an error marker
	typedef struct packed {
		job_kind_t   kind;
		logic [20:0] cp;
		logic [1:0]  last_idx;
		logic        last;
	} job_t;

	function automatic logic [1:0] utf8_last_idx(input logic [20:0] cp);
		logic [1:0] r;
		if (cp < 21'h80) begin
			r = 2'd0;
		end else if (cp < 21'h800) begin
			r = 2'd1;
		end else if (cp < SUPP_BASE) begin
			r = 2'd2;
		end else begin
			r = 2'd3;
		end
		return r;
	endfunction

	function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] last_idx,
			input logic [1:0] idx);
		logic [7:0] b;
		b = CONT;
		case (last_idx)
			2'd0: b = {1'b0, cp[6:0]};
			2'd1: b = (idx == 2'd0) ? (LEAD_2 | {3'b000, cp[10:6]}) : (CONT | {2'b00, cp[5:0]});
			2'd2: begin
				case (idx)
					2'd0: b = LEAD_3 | {4'b0000, cp[15:12]};
					2'd1: b = CONT | {2'b00, cp[11:6]};
					default: b = CONT | {2'b00, cp[5:0]};
				endcase
			end
			default: begin
				case (idx)
					2'd0: b = LEAD_4 | {5'b00000, cp[20:18]};
					2'd1: b = CONT | {2'b00, cp[17:12]};
					2'd2: b = CONT | {2'b00, cp[11:6]};
					default: b = CONT | {2'b00, cp[5:0]};
				endcase
			end
		endcase
		return b;
	endfunction

endpackage

// File: rtl/u16u8_front.sv
module u16u8_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  u16u8_pkg::in_beat_t in_beat,
	input  logic                q_full,
	output logic                push,
	output u16u8_pkg::job_t     push_job
);
	import u16u8_pkg::*;

	logic       high_pending_q;
	logic [9:0] high_bits_q;
	logic       error_latched_q;

	logic       accept;
	logic       is_high;
	logic       is_low;
	logic       last;
	logic [20:0] pair_cp;
	logic [20:0] enc_cp;
	logic       emit_char;
	logic       emit_err;
	logic       hp_d;
	logic       err_d;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign is_high  = in_beat.code_unit[15:10] == SURR_HIGH_TAG;
	assign is_low   = in_beat.code_unit[15:10] == SURR_LOW_TAG;
	assign last     = in_beat.last_unit;
	assign pair_cp  = SUPP_BASE + {1'b0, high_bits_q, in_beat.code_unit[9:0]};

	// classify the unit against the held state
	always_comb begin
		emit_char = 1'b0;
		emit_err  = 1'b0;
		hp_d      = 1'b0;
		err_d     = 1'b0;
		enc_cp    = {5'd0, in_beat.code_unit};
		if (error_latched_q) begin
			emit_err = last;
			err_d    = !last;
		end else if (high_pending_q) begin
			if (is_low) begin
				emit_char = 1'b1;
				enc_cp    = pair_cp;
			end else begin
				emit_err = last;
				err_d    = !last;
			end
		end else if (is_high) begin
			emit_err = last;
			hp_d     = !last;
		end else begin
			emit_char = 1'b1;
		end
	end

	assign push              = accept && (emit_char || emit_err);
	assign push_job.kind     = emit_err ? JOB_ERR : JOB_CHAR;
	assign push_job.cp       = enc_cp;
	assign push_job.last_idx = emit_err ? 2'd0 : utf8_last_idx(enc_cp);
	assign push_job.last     = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_pending_q  <= 1'b0;
			error_latched_q <= 1'b0;
		end else if (accept) begin
			high_pending_q  <= hp_d;
			error_latched_q <= err_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !error_latched_q && !high_pending_q && is_high) begin
			high_bits_q <= in_beat.code_unit[9:0];
		end
	end

endmodule

// File: rtl/u16u8_queue.sv
module u16u8_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  u16u8_pkg::job_t push_job,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output u16u8_pkg::job_t head_job
);
	import u16u8_pkg::*;

	localparam int DEPTH = 2 ** QUEUE_AW;

	job_t                mem [DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign full       = count_q == (QUEUE_AW + 1)'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_job   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + (QUEUE_AW + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QUEUE_AW + 1)'(1);
			end
		end
	end

`include "utf16_to_utf8_transcoder_top_assert.svh"

	`U16U8_ASSERT_IMP(a_no_push_full, push, !full, "push into full queue")
	`U16U8_ASSERT_IMP(a_no_pop_empty, pop, head_valid, "pop from empty queue")
	`U16U8_ASSERT_IMP(a_count_range, 1'b1, count_q <= (QUEUE_AW + 1)'(DEPTH),
		"queue count out of range")

endmodule

// File: rtl/u16u8_back.sv
module u16u8_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  u16u8_pkg::job_t      head_job,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output u16u8_pkg::out_beat_t out_beat
);
	import u16u8_pkg::*;

	logic      out_valid_q;
	out_beat_t out_beat_q;
	logic [1:0] idx_q;
	logic      load;
	logic      final_byte;
	out_beat_t next_beat;

	assign load       = head_valid && (!out_valid_q || out_ready);
	assign final_byte = idx_q == head_job.last_idx;
	assign pop        = load && final_byte;

	always_comb begin
		if (head_job.kind == JOB_ERR) begin
			next_beat.out_byte     = 8'd0;
			next_beat.char_done    = 1'b0;
			next_beat.string_done  = 1'b1;
			next_beat.bad_sequence = 1'b1;
		end else begin
			next_beat.out_byte     = utf8_byte(head_job.cp, head_job.last_idx, idx_q);
			next_beat.char_done    = final_byte;
			next_beat.string_done  = final_byte && head_job.last;
			next_beat.bad_sequence = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 2'd0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= final_byte ? 2'd0 : idx_q + 2'd1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_beat_q <= next_beat;
		end
	end

	assign out_valid = out_valid_q;
	assign out_beat  = out_beat_q;

`include "utf16_to_utf8_transcoder_top_assert.svh"

	`U16U8_ASSERT_IMP(a_idx_in_job, head_valid, idx_q <= head_job.last_idx,
		"byte index past end of character")
	`U16U8_ASSERT_IMP(a_err_shape, out_valid_q && out_beat_q.bad_sequence,
		out_beat_q.string_done && !out_beat_q.char_done && out_beat_q.out_byte == 8'd0,
		"malformed error beat")
	`U16U8_ASSERT_IMP(a_end_on_char,
		out_valid_q && out_beat_q.string_done && !out_beat_q.bad_sequence,
		out_beat_q.char_done, "string end off a character boundary")

endmodule

// File: rtl/utf16_to_utf8_transcoder_top.sv
// channel | dir | handshake            | payload
// input   | in  | in_valid / in_ready   | in_beat  (code_unit, last_unit)
// output  | out | out_valid / out_ready | out_beat (out_byte, char_done, string_done,
//         |     |                       |           bad_sequence)
//
// one utf-16 unit is taken per cycle while the job queue has room
// each output beat carries one utf-8 byte, so a unit yields one beat per byte:
//   1 to 3 beats for a bmp unit, 4 for a surrogate pair, 0 for a held high surrogate
// the byte sequencer and its single output register set the sustained rate
// reset clears the surrogate/error state, the job queue and the output register
// either side may stall freely; the two-entry queue absorbs the difference
module utf16_to_utf8_transcoder_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  u16u8_pkg::in_beat_t  in_beat,
	output logic                 out_valid,
	input  logic                 out_ready,
	output u16u8_pkg::out_beat_t out_beat
);
	import u16u8_pkg::*;

	// front to queue
	logic push;
	job_t push_job;
	logic q_full;

	// queue to back
	logic head_valid;
	job_t head_job;
	logic pop;

	// front: surrogate pairing and error tracking, one job per beat that yields output
	u16u8_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_beat  (in_beat),
		.q_full   (q_full),
		.push     (push),
		.push_job (push_job)
	);

	// short job queue so the front keeps taking units while bytes drain
	u16u8_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	// back: steps through the bytes of each job into the output register
	u16u8_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_beat   (out_beat)
	);

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

	import u16u8_pkg::*;

	// longest stretch with no beat on either channel before the run is abandoned
	localparam int QUIET_LIMIT = 2000;
	// receiver hold-off, long enough to fill the job queue and stall the input
	localparam int HOLD_CYCLES = 120;
	// target number of input units for the whole run
	localparam int UNIT_TARGET = 460;
	// idle cycles after the last expected beat, to catch stray output
	localparam int DRAIN_CYCLES = 16;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_beat_t  in_beat;
	logic      out_valid;
	logic      out_ready;
	out_beat_t out_beat;

	utf16_to_utf8_transcoder_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_beat  (in_beat),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_beat (out_beat)
	);

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// predictor: surrogate pairing and utf-8 encoding
	// ------------------------------------------------------------------

	// pairing state, mirrored from the block's view of the string
	logic       pend_high;
	logic [9:0] held_bits;
	logic       err_latched;

	// bytes produced by the unit being predicted
	out_beat_t utf8_pred [4];
	int        utf8_pred_n;

	// expected output beats, oldest first
	out_beat_t utf8_bytes_due [$];

	int mismatches   = 0;
	int units_sent   = 0;
	int strings_sent = 0;
	int beats_seen   = 0;
	int err_beats    = 0;

	// sender burst bookkeeping
	int burst_left   = 0;
	bit no_gaps      = 1'b0;
	bit hold_req     = 1'b0;

	function automatic out_beat_t ob(input logic [7:0] b, input logic c, input logic s,
			input logic e);
		out_beat_t r;
		r.out_byte     = b;
		r.char_done    = c;
		r.string_done  = s;
		r.bad_sequence = e;
		return r;
	endfunction

	// split a code point into its utf-8 bytes
	task automatic encode_point(input logic [20:0] cp, input logic last);
		logic [7:0] bytes [4];
		int n;
		if (cp < 21'h80) begin
			bytes[0] = cp[7:0];
			n = 1;
		end else if (cp < 21'h800) begin
			bytes[0] = LEAD_2 + {3'b000, cp[10:6]};
			bytes[1] = CONT + {2'b00, cp[5:0]};
			n = 2;
		end else if (cp < SUPP_BASE) begin
			bytes[0] = LEAD_3 + {4'b0000, cp[15:12]};
			bytes[1] = CONT + {2'b00, cp[11:6]};
			bytes[2] = CONT + {2'b00, cp[5:0]};
			n = 3;
		end else begin
			bytes[0] = LEAD_4 + {5'b00000, cp[20:18]};
			bytes[1] = CONT + {2'b00, cp[17:12]};
			bytes[2] = CONT + {2'b00, cp[11:6]};
			bytes[3] = CONT + {2'b00, cp[5:0]};
			n = 4;
		end
		for (int i = 0; i < n; i++)
			utf8_pred[i] = ob(bytes[i], i == n - 1, (i == n - 1) && last, 1'b0);
		utf8_pred_n = n;
	endtask

	// one accepted unit: update the pairing state and work out the bytes it yields
	task automatic transcode_unit(input in_beat_t b);
		logic is_hi;
		logic is_lo;
		is_hi = b.code_unit[15:10] == SURR_HIGH_TAG;
		is_lo = b.code_unit[15:10] == SURR_LOW_TAG;
		utf8_pred_n = 0;
		if (err_latched) begin
			// string already broken: only its last unit speaks
			if (b.last_unit) begin
				utf8_pred[0] = ob(8'h00, 1'b0, 1'b1, 1'b1);
				utf8_pred_n = 1;
			end
		end else if (pend_high) begin
			if (is_lo) begin
				encode_point(SUPP_BASE + {1'b0, held_bits, b.code_unit[9:0]}, b.last_unit);
			end else if (b.last_unit) begin
				utf8_pred[0] = ob(8'h00, 1'b0, 1'b1, 1'b1);
				utf8_pred_n = 1;
			end else begin
				err_latched = 1'b1;
			end
			pend_high = 1'b0;
			held_bits = '0;
		end else if (is_hi) begin
			if (b.last_unit) begin
				utf8_pred[0] = ob(8'h00, 1'b0, 1'b1, 1'b1);
				utf8_pred_n = 1;
			end else begin
				pend_high = 1'b1;
				held_bits = b.code_unit[9:0];
			end
		end else begin
			// any other unit, lone low surrogates included, is a code point by itself
			encode_point({5'b00000, b.code_unit}, b.last_unit);
		end
		if (b.last_unit) begin
			pend_high   = 1'b0;
			held_bits   = '0;
			err_latched = 1'b0;
		end
	endtask

	// ------------------------------------------------------------------
	// input side: bursts of beats with random gaps between them
	// ------------------------------------------------------------------

	task automatic send_unit(input in_beat_t b);
		int gap;
		if (burst_left == 0) begin
			gap = no_gaps ? 0 : $urandom_range(0, 6);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		in_beat  <= b;
		// hold the beat until the block takes it
		do
			@(posedge clk);
		while (!in_ready);
		units_sent++;
		if (b.last_unit)
			strings_sent++;
	endtask

	// ------------------------------------------------------------------
	// output side: receiver stall pattern, with one long hold-off on request
	// ------------------------------------------------------------------

	initial begin
		int rx_cycle;
		int rx_mode;
		rx_cycle = 0;
		rx_mode  = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1)
					@(negedge clk);
			end else begin
				rx_cycle++;
				if (rx_cycle % 48 == 0)
					rx_mode = $urandom_range(0, 3);
				case (rx_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= $urandom_range(0, 3) != 0;
					2: out_ready <= (rx_cycle % 3) == 0;
					default: out_ready <= 1'($urandom_range(0, 1));
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// checking: each output beat against the oldest expectation
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("%0t ns: mismatch on %s: got %02h, expected %02h", $realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && out_valid && out_ready) begin
			beats_seen++;
			if (out_beat.bad_sequence)
				err_beats++;
			if (utf8_bytes_due.size() == 0) begin
				report_mismatch("unexpected beat", out_beat.out_byte, 8'h00);
			end else begin
				want = utf8_bytes_due.pop_front();
				if (out_beat.out_byte !== want.out_byte)
					report_mismatch("out_byte", out_beat.out_byte, want.out_byte);
				if (out_beat.char_done !== want.char_done)
					report_mismatch("char_done", {7'd0, out_beat.char_done},
						{7'd0, want.char_done});
				if (out_beat.string_done !== want.string_done)
					report_mismatch("string_done", {7'd0, out_beat.string_done},
						{7'd0, want.string_done});
				if (out_beat.bad_sequence !== want.bad_sequence)
					report_mismatch("bad_sequence", {7'd0, out_beat.bad_sequence},
						{7'd0, want.bad_sequence});
			end
		end
	end

	// ------------------------------------------------------------------
	// watchdog: cycles with no beat moving on either channel
	// ------------------------------------------------------------------

	int quiet_cycles = 0;

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("watchdog: no beat for %0d cycles, %0d beats still due", QUIET_LIMIT,
			utf8_bytes_due.size());
		$display("TEST FAILED");
		$finish;
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------

	// directed row: a unit and, where obvious, its bytes typed in
	typedef struct {
		in_beat_t  beat;
		int        n_typed;
		out_beat_t typed [4];
	} dir_row_t;

	dir_row_t dir_tab [$];

	task automatic add_row(input logic [15:0] unit, input logic last, input int n,
			input out_beat_t e0, input out_beat_t e1, input out_beat_t e2);
		dir_row_t r;
		r.beat.code_unit = unit;
		r.beat.last_unit = last;
		r.n_typed  = n;
		r.typed[0] = e0;
		r.typed[1] = e1;
		r.typed[2] = e2;
		r.typed[3] = '0;
		dir_tab.push_back(r);
	endtask

	// send one unit, then book what it should produce
	task automatic run_unit(input in_beat_t b, input int n_typed, input out_beat_t typed [4]);
		send_unit(b);
		transcode_unit(b);
		if (n_typed > 0) begin
			for (int i = 0; i < n_typed; i++)
				utf8_bytes_due.push_back(typed[i]);
		end else begin
			for (int i = 0; i < utf8_pred_n; i++)
				utf8_bytes_due.push_back(utf8_pred[i]);
		end
	endtask

	initial begin
		out_beat_t  err;
		out_beat_t  none;
		out_beat_t  no_typed [4];
		logic [15:0] units [$];
		in_beat_t   b;
		int         len;
		int         kind;
		int         pos;
		int         rand_strings;

		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_beat  = '0;
		pend_high   = 1'b0;
		held_bits   = '0;
		err_latched = 1'b0;
		err  = ob(8'h00, 1'b0, 1'b1, 1'b1);
		none = '0;
		for (int i = 0; i < 4; i++)
			no_typed[i] = '0;

		// directed rows; n = 0 leaves the row to the predictor
		add_row(16'h0000, 1'b1, 1, ob(8'h00, 1'b1, 1'b1, 1'b0), none, none);
		add_row(16'h007F, 1'b1, 1, ob(8'h7F, 1'b1, 1'b1, 1'b0), none, none);
		add_row(16'h0080, 1'b0, 0, none, none, none);           // two-byte floor
		add_row(16'h07FF, 1'b0, 0, none, none, none);           // two-byte ceiling
		add_row(16'h0800, 1'b0, 0, none, none, none);           // three-byte floor
		add_row(16'hFFFF, 1'b1, 3, ob(8'hEF, 1'b0, 1'b0, 1'b0),
			ob(8'hBF, 1'b0, 1'b0, 1'b0), ob(8'hBF, 1'b1, 1'b1, 1'b0));
		add_row(16'hD800, 1'b0, 0, none, none, none);           // lowest pair
		add_row(16'hDC00, 1'b1, 0, none, none, none);
		add_row(16'hDBFF, 1'b0, 0, none, none, none);           // highest pair
		add_row(16'hDFFF, 1'b0, 0, none, none, none);
		add_row(16'hDC00, 1'b1, 0, none, none, none);           // lone low, end of string
		add_row(16'hDFFF, 1'b0, 0, none, none, none);           // lone low mid-string
		add_row(16'hD800, 1'b1, 1, err, none, none);            // high surrogate ends string
		add_row(16'hD9AB, 1'b0, 0, none, none, none);           // high then non-low
		add_row(16'h0041, 1'b0, 0, none, none, none);           // non-low after high: error latched, unit dropped
		add_row(16'hDC00, 1'b0, 0, none, none, none);           // dropped after error
		add_row(16'h1234, 1'b1, 1, err, none, none);
		add_row(16'hDBFF, 1'b0, 0, none, none, none);           // high then high at end
		add_row(16'hD800, 1'b1, 1, err, none, none);
		add_row(16'hDABC, 1'b0, 0, none, none, none);           // high then bmp, error at end
		add_row(16'hE000, 1'b0, 0, none, none, none);
		add_row(16'h0000, 1'b1, 1, err, none, none);
		add_row(16'h5555, 1'b0, 0, none, none, none);
		add_row(16'hAAAA, 1'b1, 0, none, none, none);

		repeat (2)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_tab[i])
			run_unit(dir_tab[i].beat, dir_tab[i].n_typed, dir_tab[i].typed);

		// random strings: mostly well formed, some broken on purpose
		rand_strings = 0;
		while (units_sent < UNIT_TARGET) begin
			units.delete();
			len = $urandom_range(1, 8);
			while (units.size() < len) begin
				kind = $urandom_range(0, 9);
				if (kind <= 2) begin
					units.push_back(16'($urandom_range(0, 16'h007F)));
				end else if (kind <= 4) begin
					units.push_back(16'($urandom_range(16'h0080, 16'h07FF)));
				end else if (kind <= 6) begin
					units.push_back(16'($urandom_range(16'h0800, 16'hFFFF)));
					// keep well-formed three-byte units out of the surrogate range
					if (units[units.size() - 1][15:11] == 5'b11011)
						units[units.size() - 1] ^= 16'h4000;
				end else begin
					units.push_back(16'hD800 + 16'($urandom_range(0, 1023)));
					units.push_back(16'hDC00 + 16'($urandom_range(0, 1023)));
				end
			end
			if ($urandom_range(0, 99) < 20) begin
				// noise: a random unit, a stray high or a stray low somewhere
				pos = $urandom_range(0, units.size() - 1);
				case ($urandom_range(0, 3))
					0: units[pos] = 16'($urandom_range(0, 16'hFFFF));
					1: units[pos] = 16'hD800 + 16'($urandom_range(0, 1023));
					2: units[pos] = 16'hDC00 + 16'($urandom_range(0, 1023));
					default: units[units.size() - 1] = 16'hD800 + 16'($urandom_range(0, 1023));
				endcase
			end

			// a run of strings with no sender gaps, and one long receiver hold-off
			no_gaps = (rand_strings >= 15 && rand_strings < 30);
			if (rand_strings == 40)
				hold_req = 1'b1;

			foreach (units[i]) begin
				b.code_unit = units[i];
				b.last_unit = (i == units.size() - 1);
				run_unit(b, 0, no_typed);
			end
			rand_strings++;
		end

		@(negedge clk);
		in_valid <= 1'b0;

		// wait out the remaining bytes, then a little longer for anything stray
		while (utf8_bytes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		$display("covered %0d units in %0d strings (%0d random), %0d output beats checked",
			units_sent, strings_sent, rand_strings, beats_seen);
		$display("%0d error beats, %0d mismatches, one %0d-cycle receiver hold-off",
			err_beats, mismatches, HOLD_CYCLES);
		if (mismatches == 0 && utf8_bytes_due.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
